[sv/mrc_pkg.sv]
`timescale 1ns / 1ps

package mrc_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_REGS_DEF    = 24;
  localparam int FRAME_DEPTH_DEF = 64;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_KIND   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEVICE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COUNT  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_START  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_VALUE  = 3'd4;

  // Request kinds
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_SINGLE = 2'd1;
  localparam logic [1:0] KIND_COIL   = 2'd2;
  localparam logic [1:0] KIND_MULTI  = 2'd3;

  // Function codes
  localparam logic [7:0] FC_READ   = 8'h03;
  localparam logic [7:0] FC_SINGLE = 8'h06;
  localparam logic [7:0] FC_COIL   = 8'h05;
  localparam logic [7:0] FC_MULTI  = 8'h10;

  // Status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TRANSPORT = 4'd1;
  localparam logic [3:0] ST_HEADER    = 4'd2;
  localparam logic [3:0] ST_CRC       = 4'd3;
  localparam logic [3:0] ST_BYTE_CNT  = 4'd4;
  localparam logic [3:0] ST_ADDR_ECHO = 4'd5;
  localparam logic [3:0] ST_SHORT_WR  = 4'd6;
  localparam logic [3:0] ST_CNT_ECHO  = 4'd7;
  localparam logic [3:0] ST_VAL_ECHO  = 4'd8;

  // Frame constants
  localparam logic [7:0]  MIN_LEN   = 8'd5;
  localparam logic [7:0]  WRITE_LEN = 8'd8;
  localparam logic [7:0]  LEN_SAT   = 8'd255;
  localparam int          HDR_BYTES = 6;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_frame;
    logic       transport_fail;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] reg_value;
    logic [4:0]  reg_index;
    logic        reg_valid;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  device;
    logic [4:0]  count;
    logic [15:0] start;
    logic [15:0] value;
  } cfg_t;

  typedef enum logic {
    Q_WRITE,
    Q_VERDICT
  } q_op_t;

  typedef struct packed {
    q_op_t      op;
    logic [7:0] addr;
    logic [7:0] data;
    logic [3:0] status;
    logic [4:0] count;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic room2;
  } q_status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CRC,
    F_VERD
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_HI,
    B_LO,
    B_OUT
  } back_state_t;

  function automatic logic [7:0] func_code(input logic [1:0] kind);
    logic [7:0] fc;
    case (kind)
      KIND_READ:   fc = FC_READ;
      KIND_SINGLE: fc = FC_SINGLE;
      KIND_COIL:   fc = FC_COIL;
      default:     fc = FC_MULTI;
    endcase
    return fc;
  endfunction

endpackage

[sv/mrc_front.sv]
`timescale 1ns / 1ps

module mrc_front #(
  parameter int MAX_REGS    = mrc_pkg::MAX_REGS_DEF,
  parameter int FRAME_DEPTH = mrc_pkg::FRAME_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mrc_pkg::in_item_t  in_data,
  input  mrc_pkg::cfg_t      cfg,
  input  mrc_pkg::q_status_t q_stat,
  output logic               q_push,
  output mrc_pkg::q_entry_t  q_entry
);

  mrc_pkg::front_state_t state, state_next;

  logic [7:0]  len;
  logic [15:0] crc;
  logic [15:0] tail;
  logic [7:0]  hdr [mrc_pkg::HDR_BYTES];
  logic [2:0]  bitcnt;
  logic        eof_q;
  logic        fail_q;

  logic       accept;
  logic       take_byte;
  logic       need_crc;
  logic       store_byte;
  logic [3:0] st;
  logic [7:0] need_len;
  logic [7:0] twice_cnt;

  assign accept     = in_valid && !in_stall;
  assign take_byte  = in_data.has_byte && (len != mrc_pkg::LEN_SAT);
  assign need_crc   = take_byte && (len >= 8'd2);
  assign store_byte = take_byte && ({1'b0, len} < 9'(FRAME_DEPTH));
  assign twice_cnt  = {2'b00, cfg.count, 1'b0};
  assign need_len   = mrc_pkg::MIN_LEN + twice_cnt;

  // Verdict: first failing check wins
  always_comb begin
    st = mrc_pkg::ST_OK;
    if (fail_q) begin
      st = mrc_pkg::ST_TRANSPORT;
    end else if (len < mrc_pkg::MIN_LEN || hdr[0] != cfg.device ||
                 hdr[1] != mrc_pkg::func_code(cfg.kind)) begin
      st = mrc_pkg::ST_HEADER;
    end else if (crc != tail) begin
      st = mrc_pkg::ST_CRC;
    end else if (cfg.kind == mrc_pkg::KIND_READ) begin
      if ({3'b000, cfg.count} > 8'(MAX_REGS) || len < need_len || hdr[2] != twice_cnt) begin
        st = mrc_pkg::ST_BYTE_CNT;
      end
    end else if (hdr[2] != cfg.start[15:8] || hdr[3] != cfg.start[7:0]) begin
      st = mrc_pkg::ST_ADDR_ECHO;
    end else if (len < mrc_pkg::WRITE_LEN) begin
      st = mrc_pkg::ST_SHORT_WR;
    end else if (cfg.kind == mrc_pkg::KIND_MULTI) begin
      if (hdr[4] != 8'h00 || hdr[5] != {3'b000, cfg.count}) begin
        st = mrc_pkg::ST_CNT_ECHO;
      end
    end else if ({hdr[4], hdr[5]} != cfg.value) begin
      st = mrc_pkg::ST_VAL_ECHO;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    q_push     = 1'b0;
    q_entry    = '0;
    case (state)
      mrc_pkg::F_IDLE: begin
        // keep room for this beat's write and a following verdict
        in_stall      = !q_stat.room2;
        q_entry.op    = mrc_pkg::Q_WRITE;
        q_entry.addr  = len;
        q_entry.data  = in_data.data_byte;
        if (accept) begin
          q_push = store_byte;
          if (need_crc) begin
            state_next = mrc_pkg::F_CRC;
          end else if (in_data.end_of_frame) begin
            state_next = mrc_pkg::F_VERD;
          end
        end
      end
      mrc_pkg::F_CRC: begin
        if (bitcnt == 3'd7) begin
          state_next = eof_q ? mrc_pkg::F_VERD : mrc_pkg::F_IDLE;
        end
      end
      mrc_pkg::F_VERD: begin
        q_push         = 1'b1;
        q_entry.op     = mrc_pkg::Q_VERDICT;
        q_entry.status = st;
        q_entry.count  = (st == mrc_pkg::ST_OK && cfg.kind == mrc_pkg::KIND_READ) ?
                         cfg.count : 5'd0;
        state_next     = mrc_pkg::F_IDLE;
      end
      default: state_next = mrc_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrc_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len    <= '0;
      crc    <= mrc_pkg::CRC_INIT;
      tail   <= '0;
      bitcnt <= '0;
      for (int i = 0; i < mrc_pkg::HDR_BYTES; i++) hdr[i] <= '0;
    end else begin
      case (state)
        mrc_pkg::F_IDLE: begin
          bitcnt <= '0;
          if (accept && take_byte) begin
            tail <= {in_data.data_byte, tail[15:8]};
            len  <= len + 8'd1;
            if (len < 8'(mrc_pkg::HDR_BYTES)) hdr[len[2:0]] <= in_data.data_byte;
            // fold in the byte leaving the held-back pair
            if (need_crc) crc <= crc ^ {8'h00, tail[7:0]};
          end
        end
        mrc_pkg::F_CRC: begin
          bitcnt <= bitcnt + 3'd1;
          crc    <= crc[0] ? ((crc >> 1) ^ mrc_pkg::CRC_POLY) : (crc >> 1);
        end
        mrc_pkg::F_VERD: begin
          len  <= '0;
          crc  <= mrc_pkg::CRC_INIT;
          tail <= '0;
          for (int i = 0; i < mrc_pkg::HDR_BYTES; i++) hdr[i] <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      eof_q  <= in_data.end_of_frame;
      fail_q <= in_data.transport_fail;
    end
  end

endmodule

[sv/mrc_queue.sv]
`timescale 1ns / 1ps

module mrc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mrc_pkg::q_entry_t  push_entry,
  input  logic               pop,
  output mrc_pkg::q_entry_t  head,
  output mrc_pkg::q_status_t stat
);

  mrc_pkg::q_entry_t entries [mrc_pkg::QDEPTH];

  logic [mrc_pkg::QPTR_W-1:0] wptr;
  logic [mrc_pkg::QPTR_W-1:0] rptr;
  logic [mrc_pkg::QPTR_W:0]   count;

  assign head       = entries[rptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (mrc_pkg::QPTR_W+1)'(mrc_pkg::QDEPTH));
  assign stat.room2 = (count <= (mrc_pkg::QPTR_W+1)'(mrc_pkg::QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_entry;
  end

endmodule

[sv/mrc_back.sv]
`timescale 1ns / 1ps

module mrc_back #(
  parameter int FRAME_DEPTH = mrc_pkg::FRAME_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  mrc_pkg::q_entry_t  head,
  input  mrc_pkg::q_status_t q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output mrc_pkg::out_item_t out_data
);

  localparam int AW = $clog2(FRAME_DEPTH);

  mrc_pkg::back_state_t state, state_next;

  logic [7:0] mem [FRAME_DEPTH];
  logic [7:0] rdata;
  logic       rzero;

  logic [4:0] idx;
  logic [4:0] cnt;
  logic [7:0] hi_byte;

  logic               load;
  logic               ld_ok;
  logic               mem_we;
  logic               rd_en;
  logic               start_emit;
  logic [8:0]         hi_pos;
  logic [8:0]         rd_pos;
  logic               in_range;
  logic [7:0]         rbyte;
  logic               is_last;
  mrc_pkg::out_item_t out_next;

  assign ld_ok    = !out_valid || !out_stall;
  assign hi_pos   = 9'd3 + {3'b000, idx, 1'b0};
  assign rd_pos   = (state == mrc_pkg::B_LO) ? hi_pos + 9'd1 : hi_pos;
  assign in_range = rd_pos < 9'(FRAME_DEPTH);
  assign rbyte    = rzero ? 8'h00 : rdata;
  assign is_last  = (idx + 5'd1) == cnt;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load       = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    start_emit = 1'b0;
    out_next   = '0;
    case (state)
      mrc_pkg::B_IDLE: begin
        out_next.status = head.status;
        out_next.last   = 1'b1;
        if (!q_stat.empty) begin
          if (head.op == mrc_pkg::Q_WRITE) begin
            pop    = 1'b1;
            mem_we = 1'b1;
          end else if (head.count != 5'd0) begin
            pop        = 1'b1;
            start_emit = 1'b1;
            state_next = mrc_pkg::B_HI;
          end else if (ld_ok) begin
            pop  = 1'b1;
            load = 1'b1;
          end
        end
      end
      mrc_pkg::B_HI: begin
        rd_en      = 1'b1;
        state_next = mrc_pkg::B_LO;
      end
      mrc_pkg::B_LO: begin
        rd_en      = 1'b1;
        state_next = mrc_pkg::B_OUT;
      end
      mrc_pkg::B_OUT: begin
        out_next.status    = mrc_pkg::ST_OK;
        out_next.reg_value = {hi_byte, rbyte};
        out_next.reg_index = idx;
        out_next.reg_valid = 1'b1;
        out_next.last      = is_last;
        if (ld_ok) begin
          load       = 1'b1;
          state_next = is_last ? mrc_pkg::B_IDLE : mrc_pkg::B_HI;
        end
      end
      default: state_next = mrc_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrc_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[head.addr[AW-1:0]] <= head.data;
    if (rd_en) begin
      rdata <= mem[rd_pos[AW-1:0]];
      rzero <= !in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (start_emit) begin
      cnt <= head.count;
      idx <= '0;
    end else if (state == mrc_pkg::B_OUT && load) begin
      idx <= idx + 5'd1;
    end
    if (state == mrc_pkg::B_LO) hi_byte <= rbyte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= out_next;
  end

endmodule

[sv/modbus_rtu_response_checker.sv]
`timescale 1ns / 1ps

// Modbus RTU reply checker.
// Input channel (in_valid / in_stall / in_data): one beat per received reply
// byte; end_of_frame closes the reply and transport_fail is sampled with it.
// Output channel (out_valid / out_stall / out_data): a successful read gives
// one beat per register, any other outcome a single beat with the status;
// last marks the final beat of each reply.
// Configuration port (cfg_we / cfg_addr / cfg_data): write the expected
// request while the block is idle; indexes 0..4 are kind, device, count,
// start and value, other indexes are ignored.
// Input pacing: a byte that enters the CRC is accepted and then folded in by the
// bit-serial CRC shifter, while the input stalls; the first two bytes of a frame
// and beats with no byte skip the shifter; end of frame adds a verdict step.
// The front keeps taking bytes of the next reply while the back
// still streams registers, until fewer than two of the 4 queue entries are free.
// Each register beat goes through B_HI and B_LO (two reads of the byte store per
// beat) and waits in B_OUT while the output is stalled. With the back idle, a
// status beat leaves through the verdict step, queue and output register after
// the end of frame beat (and the CRC shifter if that byte enters the CRC).
// Reset is synchronous: frame state, queue and output clear, registers return to
// their defaults. A stalled output holds its beat and backs up the queue.
module modbus_rtu_response_checker #(
  parameter int MAX_REGS    = mrc_pkg::MAX_REGS_DEF,
  parameter int FRAME_DEPTH = mrc_pkg::FRAME_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mrc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mrc_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [mrc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mrc_pkg::CFG_DATA_W-1:0] cfg_data
);

  mrc_pkg::cfg_t      cfg;
  mrc_pkg::q_status_t q_stat;
  mrc_pkg::q_entry_t  q_entry;
  mrc_pkg::q_entry_t  q_head;
  logic               q_push;
  logic               q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kind   <= mrc_pkg::KIND_READ;
      cfg.device <= 8'd1;
      cfg.count  <= 5'd1;
      cfg.start  <= '0;
      cfg.value  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        mrc_pkg::REG_KIND:   cfg.kind   <= cfg_data[1:0];
        mrc_pkg::REG_DEVICE: cfg.device <= cfg_data[7:0];
        mrc_pkg::REG_COUNT:  cfg.count  <= cfg_data[4:0];
        mrc_pkg::REG_START:  cfg.start  <= cfg_data;
        mrc_pkg::REG_VALUE:  cfg.value  <= cfg_data;
        default: ;
      endcase
    end
  end

  mrc_front #(
    .MAX_REGS    (MAX_REGS),
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  mrc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  mrc_back #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.reg_valid |->
      out_data.last && out_data.reg_value == 16'h0000 && out_data.reg_index == 5'd0)
    else $error("non-register beat malformed");

  a_reg_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.reg_valid |-> out_data.status == mrc_pkg::ST_OK)
    else $error("register beat with failing status");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE      = 20;
  localparam int PHASE_BEATS = 10;
  localparam int NUM_PHASES  = 8;

  typedef enum int {
    GOOD, LINK_ERR, BAD_DEV, BAD_FUNC, BAD_CRC, BAD_BCNT,
    BAD_ADDR, TRUNC, BAD_CNT, BAD_VAL, PADDED, JUNK
  } flaw_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  mrc_pkg::in_item_t              in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  mrc_pkg::out_item_t             out_data;
  logic                           cfg_we = 1'b0;
  logic [mrc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [mrc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  modbus_rtu_response_checker u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the request registers
  logic [1:0]  want_kind;
  logic [7:0]  want_dev;
  logic [4:0]  want_cnt;
  logic [15:0] want_start;
  logic [15:0] want_val;

  // Shadow of the reply being received
  logic [7:0]  frm_len = 8'd0;
  logic [15:0] crc_acc = mrc_pkg::CRC_INIT;
  logic [15:0] tail = 16'h0000;
  logic [7:0]  frm_bytes [mrc_pkg::FRAME_DEPTH_DEF];

  mrc_pkg::in_item_t  rx_beats_q [$];
  mrc_pkg::out_item_t outcome_q [$];
  logic [7:0]         frame_buf [$];
  mrc_pkg::out_item_t want;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_go = 1'b0;
  int hold_left;
  int quiet;
  int mismatches = 0;
  int results_seen = 0;
  int beats_sent = 0;
  int replies_sent = 0;

  always @(posedge clk) begin
    if (rst) begin
      want_kind  <= mrc_pkg::KIND_READ;
      want_dev   <= 8'd1;
      want_cnt   <= 5'd1;
      want_start <= 16'h0000;
      want_val   <= 16'h0000;
    end else if (cfg_we) begin
      case (cfg_addr)
        mrc_pkg::REG_KIND:   want_kind  <= cfg_data[1:0];
        mrc_pkg::REG_DEVICE: want_dev   <= cfg_data[7:0];
        mrc_pkg::REG_COUNT:  want_cnt   <= cfg_data[4:0];
        mrc_pkg::REG_START:  want_start <= cfg_data;
        mrc_pkg::REG_VALUE:  want_val   <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    int k;
    r = c ^ {8'h00, b};
    for (k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ mrc_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic logic [7:0] reply_code(logic [1:0] k);
    logic [7:0] fc;
    case (k)
      mrc_pkg::KIND_READ:   fc = mrc_pkg::FC_READ;
      mrc_pkg::KIND_SINGLE: fc = mrc_pkg::FC_SINGLE;
      mrc_pkg::KIND_COIL:   fc = mrc_pkg::FC_COIL;
      default:              fc = mrc_pkg::FC_MULTI;
    endcase
    return fc;
  endfunction

  function automatic logic [7:0] held_byte(int pos);
    if (pos < frm_len && pos < mrc_pkg::FRAME_DEPTH_DEF) return frm_bytes[pos];
    return 8'h00;
  endfunction

  // Fold one accepted beat into the reply and queue the verdict at end of frame
  task automatic absorb_beat(mrc_pkg::in_item_t it);
    logic [3:0]         st;
    mrc_pkg::out_item_t r;
    int                 need;
    int                 i;
    if (it.has_byte && frm_len != mrc_pkg::LEN_SAT) begin
      // the two newest bytes stay out of the CRC until displaced
      if (frm_len >= 2) crc_acc = crc_step(crc_acc, tail[7:0]);
      tail = {it.data_byte, tail[15:8]};
      if (frm_len < mrc_pkg::FRAME_DEPTH_DEF) frm_bytes[frm_len] = it.data_byte;
      frm_len = frm_len + 8'd1;
    end
    if (it.end_of_frame) begin
      need = int'(mrc_pkg::MIN_LEN) + 2 * want_cnt;
      st = mrc_pkg::ST_OK;
      if (it.transport_fail) st = mrc_pkg::ST_TRANSPORT;
      else if (frm_len < mrc_pkg::MIN_LEN || held_byte(0) != want_dev ||
               held_byte(1) != reply_code(want_kind)) st = mrc_pkg::ST_HEADER;
      else if (crc_acc != tail) st = mrc_pkg::ST_CRC;
      else if (want_kind == mrc_pkg::KIND_READ) begin
        if (want_cnt > mrc_pkg::MAX_REGS_DEF || frm_len < need ||
            held_byte(2) != 2 * want_cnt)
          st = mrc_pkg::ST_BYTE_CNT;
      end else if ({held_byte(2), held_byte(3)} != want_start) st = mrc_pkg::ST_ADDR_ECHO;
      else if (frm_len < mrc_pkg::WRITE_LEN) st = mrc_pkg::ST_SHORT_WR;
      else if (want_kind == mrc_pkg::KIND_MULTI) begin
        if (held_byte(4) != 8'h00 || held_byte(5) != want_cnt) st = mrc_pkg::ST_CNT_ECHO;
      end else if ({held_byte(4), held_byte(5)} != want_val) st = mrc_pkg::ST_VAL_ECHO;

      if (st == mrc_pkg::ST_OK && want_kind == mrc_pkg::KIND_READ && want_cnt != 0) begin
        for (i = 0; i < want_cnt; i++) begin
          r.status    = mrc_pkg::ST_OK;
          r.reg_value = {held_byte(3 + 2 * i), held_byte(4 + 2 * i)};
          r.reg_index = 5'(i);
          r.reg_valid = 1'b1;
          r.last      = (i == want_cnt - 1);
          outcome_q.insert(outcome_q.size(), r);
        end
      end else begin
        r = '0;
        r.status = st;
        r.last   = 1'b1;
        outcome_q.insert(outcome_q.size(), r);
      end
      frm_len = 8'd0;
      crc_acc = mrc_pkg::CRC_INIT;
      tail    = 16'h0000;
    end
  endtask

  // Sender: hold a stalled beat, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_beat(in_data);
        void'(rx_beats_q.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (rx_beats_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= rx_beats_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_go && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: exp st=%0d val=%h idx=%0d rv=%b last=%b",
               $time, what, want.status, want.reg_value, want.reg_index,
               want.reg_valid, want.last);
      $display("    got st=%0d val=%h idx=%0d rv=%b last=%b",
               out_data.status, out_data.reg_value, out_data.reg_index,
               out_data.reg_valid, out_data.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (outcome_q.size() == 0) begin
        want = '0;
        note_mismatch("result beat with nothing pending");
      end else begin
        want = outcome_q.pop_front();
        if (out_data.status !== want.status || out_data.reg_value !== want.reg_value ||
            out_data.reg_index !== want.reg_index || out_data.reg_valid !== want.reg_valid ||
            out_data.last !== want.last)
          note_mismatch("result beat mismatch");
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] frame_crc();
    logic [15:0] c;
    c = mrc_pkg::CRC_INIT;
    foreach (frame_buf[i]) c = crc_step(c, frame_buf[i]);
    return c;
  endfunction

  task automatic add_byte(logic [7:0] b);
    frame_buf.insert(frame_buf.size(), b);
  endtask

  // Turn frame_buf into input beats, with stray empty beats mixed in
  task automatic queue_beats(bit link_err);
    mrc_pkg::in_item_t it;
    bit                sep;
    sep = (frame_buf.size() == 0) || ($urandom_range(3) == 0);
    foreach (frame_buf[i]) begin
      if ($urandom_range(99) < 8) begin
        it.data_byte      = 8'($urandom);
        it.has_byte       = 1'b0;
        it.end_of_frame   = 1'b0;
        it.transport_fail = 1'($urandom);
        rx_beats_q.insert(rx_beats_q.size(), it);
        beats_sent++;
      end
      it.data_byte      = frame_buf[i];
      it.has_byte       = 1'b1;
      it.end_of_frame   = !sep && (i == frame_buf.size() - 1);
      it.transport_fail = it.end_of_frame ? link_err : 1'($urandom);
      rx_beats_q.insert(rx_beats_q.size(), it);
      beats_sent++;
    end
    if (sep) begin
      it.data_byte      = 8'($urandom);
      it.has_byte       = 1'b0;
      it.end_of_frame   = 1'b1;
      it.transport_fail = link_err;
      rx_beats_q.insert(rx_beats_q.size(), it);
      beats_sent++;
    end
    replies_sent++;
  endtask

  // Build a reply to the current request, damaged as asked
  task automatic send_reply(flaw_t f);
    logic [15:0] c;
    int          n;
    frame_buf.delete();
    if (f == JUNK) begin
      n = $urandom_range(12);
      repeat (n) add_byte(8'($urandom));
    end else begin
      add_byte(want_dev);
      add_byte(reply_code(want_kind));
      case (want_kind)
        mrc_pkg::KIND_READ: begin
          add_byte(8'(2 * want_cnt));
          repeat (2 * want_cnt) add_byte(8'($urandom));
        end
        mrc_pkg::KIND_MULTI: begin
          add_byte(want_start[15:8]);
          add_byte(want_start[7:0]);
          add_byte(8'h00);
          add_byte({3'b000, want_cnt});
        end
        default: begin
          add_byte(want_start[15:8]);
          add_byte(want_start[7:0]);
          add_byte(want_val[15:8]);
          add_byte(want_val[7:0]);
        end
      endcase
      case (f)
        BAD_DEV:  frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(255, 1));
        BAD_FUNC: begin
          if ($urandom_range(1) == 1) begin
            // exception reply: flagged function code and one error byte
            frame_buf[1] = frame_buf[1] | 8'h80;
            while (frame_buf.size() > 3) void'(frame_buf.pop_back());
          end else begin
            frame_buf[1] = frame_buf[1] ^ 8'($urandom_range(255, 1));
          end
        end
        BAD_BCNT: frame_buf[2] = frame_buf[2] ^ 8'($urandom_range(255, 1));
        BAD_ADDR: if (frame_buf.size() > 3) frame_buf[3] = frame_buf[3] ^ 8'($urandom_range(255, 1));
        BAD_CNT:  if (frame_buf.size() > 4) frame_buf[4] = frame_buf[4] ^ 8'($urandom_range(255, 1));
        BAD_VAL:  if (frame_buf.size() > 5) frame_buf[5] = frame_buf[5] ^ 8'($urandom_range(255, 1));
        TRUNC: begin
          n = $urandom_range(frame_buf.size() - 1, 2);
          while (frame_buf.size() > n) void'(frame_buf.pop_back());
        end
        PADDED: repeat ($urandom_range(3, 1)) add_byte(8'($urandom));
        default: ;
      endcase
      c = frame_crc();
      add_byte(c[7:0]);
      add_byte(c[15:8]);
      if (f == BAD_CRC) begin
        n = frame_buf.size() - 1 - $urandom_range(1);
        frame_buf[n] = frame_buf[n] ^ 8'($urandom_range(255, 1));
      end
    end
    queue_beats(f == LINK_ERR);
  endtask

  task automatic set_reg(logic [mrc_pkg::CFG_ADDR_W-1:0] idx,
                         logic [mrc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Wait for every beat to go in and every result to come out
  task automatic drain();
    while (rx_beats_q.size() != 0 || in_valid || outcome_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic run_phase(int ph);
    logic [1:0]  k;
    logic [7:0]  d;
    logic [4:0]  c;
    logic [15:0] s;
    logic [15:0] v;
    int          first_beat;
    k = 2'($urandom);
    d = 8'($urandom);
    c = 5'($urandom_range(8, 1));
    s = 16'($urandom);
    v = 16'($urandom);
    case (ph)
      0: begin k = mrc_pkg::KIND_READ;   d = 8'h00; c = 5'($urandom_range(4, 1)); end
      1: begin k = mrc_pkg::KIND_SINGLE; d = 8'hFF; s = 16'h0000; v = 16'hFFFF; end
      2: begin k = mrc_pkg::KIND_COIL;   s = 16'hFFFF; v = 16'h0000; end
      3: begin k = mrc_pkg::KIND_MULTI;  c = 5'd24; end
      4: begin k = mrc_pkg::KIND_READ;   d = 8'hFF; c = 5'd24; end
      5: begin k = mrc_pkg::KIND_READ;   c = 5'($urandom_range(31, 25)); end
      6: begin k = mrc_pkg::KIND_MULTI;  c = 5'($urandom_range(31, 0)); end
      default: c = 5'($urandom_range(6, 1));
    endcase
    // upper data bits are junk the block must drop
    set_reg(mrc_pkg::REG_KIND,   {14'($urandom), k});
    set_reg(mrc_pkg::REG_DEVICE, {8'($urandom), d});
    set_reg(mrc_pkg::REG_COUNT,  {11'($urandom), c});
    set_reg(mrc_pkg::REG_START,  s);
    set_reg(mrc_pkg::REG_VALUE,  v);
    set_reg((mrc_pkg::CFG_ADDR_W)'($urandom_range(7, 5)), 16'($urandom));
    @(negedge clk);
    case (ph % 4)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 55; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 55; end
      default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
    endcase
    first_beat = beats_sent;
    while (beats_sent - first_beat < PHASE_BEATS)
      send_reply(($urandom_range(1) == 1) ? GOOD : flaw_t'($urandom_range(JUNK, LINK_ERR)));
    drain();
  endtask

  initial begin
    int ph;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // registers at their reset values: read of one register from device 1;
    // hold the output off meanwhile so the queue backs up into the input
    hold_go = 1'b1;
    send_reply(GOOD);
    frame_buf.delete();
    queue_beats(1'b0);
    send_reply(LINK_ERR);
    send_reply(BAD_FUNC);
    @(negedge clk);
    hold_go = 1'b0;
    drain();

    // read of zero registers
    set_reg(mrc_pkg::REG_COUNT, '0);
    @(negedge clk);
    send_reply(GOOD);
    send_reply(BAD_BCNT);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) run_phase(ph);

    drain();
    $display("%0d replies in %0d input beats, all request kinds, four pacing modes",
             replies_sent, beats_sent);
    $display("%0d result beats checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/mrc_pkg.sv
sv/mrc_front.sv
sv/mrc_queue.sv
sv/mrc_back.sv
sv/modbus_rtu_response_checker.sv
verif/tb.sv
